// File: sv/mws_pkg.sv
// Shared constants, codes and types of the moving window sum unit.
`default_nettype none

package mws_pkg;

   localparam int DEPTH           = 256;
   localparam int ADDR_WIDTH      = $clog2(DEPTH);
   localparam int SAMPLE_WIDTH    = 32;
   localparam int TOTAL_WIDTH     = 40;
   localparam int AVG_WIDTH       = 32;
   localparam int LEN_WIDTH       = 9;
   localparam int OFFSET_WIDTH    = 9;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 9;

   localparam int WINDOW_LENGTH_RESET = 16;
   localparam int NEWEST_RESET        = WINDOW_LENGTH_RESET - 1;

   localparam int MOD_STEPS  = LEN_WIDTH;
   localparam int DIV_STEPS  = TOTAL_WIDTH;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS + 1);

   localparam logic [TOTAL_WIDTH-1:0] AVG_POS_LIMIT =
      TOTAL_WIDTH'((64'd1 << (AVG_WIDTH - 1)) - 64'd1);
   localparam logic [TOTAL_WIDTH-1:0] AVG_NEG_LIMIT =
      TOTAL_WIDTH'(64'd1 << (AVG_WIDTH - 1));
   localparam logic [AVG_WIDTH-1:0] AVG_MAX = {1'b0, {(AVG_WIDTH - 1){1'b1}}};
   localparam logic [AVG_WIDTH-1:0] AVG_MIN = {1'b1, {(AVG_WIDTH - 1){1'b0}}};

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_READ = 2'd1,
      OP_FILL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NEGATIVE = 2'd1,
      ERR_RANGE    = 2'd2
   } err_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WINDOW_LENGTH = 1'd0,
      CSR_NONNEGATIVE   = 1'd1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INDEX,
      ST_READ,
      ST_MODIFY,
      ST_FILL,
      ST_AVG_START,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// File: sv/mws_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module mws_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/moving_window_sum_unit.sv
// Moving window sum and average over signed Q16.16 samples held in a ring memory.
//
// The window samples sit in a 256 x 32 RAM with registered reads; a valid bit
// per entry makes unwritten entries read as zero, so no clearing pass follows
// reset. One item is worked on at a time. A push or an in-range read-back runs
// a 9-step ring index reduction and a 40-step average division, both on one
// shared restoring divider, plus a read of one RAM entry that a push writes
// back. A rejected push, an out-of-range read-back or an unused code runs only
// the average division. A fill writes one entry a cycle over the window length,
// then runs the average division. A new transfer is taken while the previous
// result still waits in the output register.
`default_nettype none

module moving_window_sum_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_operation,
   input  logic signed [mws_pkg::SAMPLE_WIDTH-1:0]  req_value,
   input  logic signed [mws_pkg::OFFSET_WIDTH-1:0]  req_offset,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [mws_pkg::TOTAL_WIDTH-1:0]   rsp_running_sum,
   output logic signed [mws_pkg::AVG_WIDTH-1:0]     rsp_average,
   output logic signed [mws_pkg::SAMPLE_WIDTH-1:0]  rsp_looked_up_value,
   output logic [1:0]                               rsp_error_code,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mws_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [mws_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);

   import mws_pkg::*;

   state_type state_ff, state_in;

   logic [LEN_WIDTH-1:0]    wlen_ff, wlen_in;
   logic                    nonneg_ff, nonneg_in;
   logic [ADDR_WIDTH-1:0]   newest_ff, newest_in;
   logic signed [TOTAL_WIDTH-1:0] tot_ff, tot_in;
   logic [DEPTH-1:0]        vld_ff, vld_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   op_type                  op_ff, op_in;
   logic signed [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic [LEN_WIDTH-1:0]    len_ff, len_in;
   logic [LEN_WIDTH-1:0]    negoff_ff, negoff_in;
   logic [ADDR_WIDTH-1:0]   idx_ff, idx_in;
   logic [LEN_WIDTH-1:0]    fill_ff, fill_in;
   logic [TOTAL_WIDTH-1:0]  quo_ff, quo_in;
   logic [LEN_WIDTH-1:0]    rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    avg_neg_ff, avg_neg_in;
   logic [SAMPLE_WIDTH-1:0] look_ff, look_in;
   err_type                 err_ff, err_in;
   logic                    rvld_ff;

   logic [TOTAL_WIDTH-1:0]  sum_out_ff, sum_out_in;
   logic [AVG_WIDTH-1:0]    avg_out_ff, avg_out_in;
   logic [SAMPLE_WIDTH-1:0] look_out_ff, look_out_in;
   err_type                 err_out_ff, err_out_in;

   logic                    accept;
   logic                    out_load;
   logic                    div_step;
   logic                    fill_last;
   op_type                  req_op;
   logic [LEN_WIDTH-1:0]    len_eff;
   logic signed [LEN_WIDTH:0] off_ext;
   logic [LEN_WIDTH:0]      neg_off;
   logic                    in_range;
   logic [LEN_WIDTH-1:0]    mod_dividend;

   logic [LEN_WIDTH:0]      div_shift;
   logic [LEN_WIDTH:0]      div_diff;
   logic                    div_ge;
   logic [LEN_WIDTH+1:0]    read_pos;
   logic [LEN_WIDTH+1:0]    read_wrap;

   logic signed [SAMPLE_WIDTH-1:0]  old_smp;
   logic signed [TOTAL_WIDTH+1:0]   part_tot;
   logic signed [TOTAL_WIDTH+1:0]   push_tot;
   logic signed [LEN_WIDTH+SAMPLE_WIDTH:0] fill_prod;
   logic [LEN_WIDTH-1:0]    len_m1;

   logic                    ram_we;
   logic [ADDR_WIDTH-1:0]   ram_waddr;
   logic [SAMPLE_WIDTH-1:0] ram_rdata;

   mws_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (val_ff),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_op    = op_type'(req_operation);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
   assign len_m1    = len_ff - LEN_WIDTH'(1);
   assign fill_last = (fill_ff == len_m1);

   assign len_eff = (wlen_ff == '0)               ? LEN_WIDTH'(1) :
                    (wlen_ff > LEN_WIDTH'(DEPTH)) ? LEN_WIDTH'(DEPTH) : wlen_ff;

   assign off_ext  = (LEN_WIDTH+1)'(req_offset);
   assign neg_off  = -off_ext;
   assign in_range = (req_offset <= 0) && (neg_off < {1'b0, len_eff});

   assign mod_dividend = (req_op == OP_PUSH) ? ({1'b0, newest_ff} + LEN_WIDTH'(1))
                                             : {1'b0, newest_ff};

   assign div_shift = {rem_ff, quo_ff[TOTAL_WIDTH-1]};
   assign div_diff  = div_shift - {1'b0, len_ff};
   assign div_ge    = (div_shift >= {1'b0, len_ff});

   assign read_pos  = {2'b00, rem_ff} + {2'b00, len_ff} - {2'b00, negoff_ff};
   assign read_wrap = (read_pos >= {2'b00, len_ff}) ? (read_pos - {2'b00, len_ff})
                                                    : read_pos;

   assign old_smp   = rvld_ff ? $signed(ram_rdata) : '0;
   assign fill_prod = $signed({1'b0, len_ff}) * val_ff;

   always_comb begin
      part_tot = (TOTAL_WIDTH+2)'(tot_ff) - (TOTAL_WIDTH+2)'(old_smp);
      if (nonneg_ff && part_tot < 0) begin
         part_tot = '0;
      end
      push_tot = part_tot + (TOTAL_WIDTH+2)'(val_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PUSH: state_in = (nonneg_ff && req_value < 0) ? ST_AVG_START
                                                                   : ST_INDEX;
                  OP_READ: state_in = in_range ? ST_INDEX : ST_AVG_START;
                  OP_FILL: state_in = ST_FILL;
                  default: state_in = ST_AVG_START;
               endcase
            end
         end
         ST_INDEX:     if (step_ff == '0) state_in = ST_READ;
         ST_READ:      state_in = ST_MODIFY;
         ST_MODIFY:    state_in = ST_AVG_START;
         ST_FILL:      if (fill_last) state_in = ST_AVG_START;
         ST_AVG_START: state_in = ST_DIVIDE;
         ST_DIVIDE:    if (step_ff == '0) state_in = ST_RESULT;
         ST_RESULT:    if (out_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = reset || (state_ff != ST_IDLE);
      csr_ready = !reset;
      ram_we    = (state_ff == ST_FILL) || ((state_ff == ST_MODIFY) && (op_ff == OP_PUSH));
      ram_waddr = (state_ff == ST_FILL) ? fill_ff[ADDR_WIDTH-1:0] : idx_ff;
      div_step  = ((state_ff == ST_INDEX) || (state_ff == ST_DIVIDE)) && (step_ff != '0);
   end

   // datapath
   always_comb begin
      wlen_in     = wlen_ff;
      nonneg_in   = nonneg_ff;
      newest_in   = newest_ff;
      tot_in      = tot_ff;
      vld_in      = vld_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      len_in      = len_ff;
      negoff_in   = negoff_ff;
      idx_in      = idx_ff;
      fill_in     = fill_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      avg_neg_in  = avg_neg_ff;
      look_in     = look_ff;
      err_in      = err_ff;
      sum_out_in  = sum_out_ff;
      avg_out_in  = avg_out_ff;
      look_out_in = look_out_ff;
      err_out_in  = err_out_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_type'(csr_index))
            CSR_WINDOW_LENGTH: wlen_in   = csr_wdata[LEN_WIDTH-1:0];
            CSR_NONNEGATIVE:   nonneg_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (ram_we) begin
         vld_in[ram_waddr] = 1'b1;
      end

      if (div_step) begin
         rem_in  = div_ge ? div_diff[LEN_WIDTH-1:0] : div_shift[LEN_WIDTH-1:0];
         quo_in  = {quo_ff[TOTAL_WIDTH-2:0], div_ge};
         step_in = step_ff - STEP_WIDTH'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               val_in    = req_value;
               len_in    = len_eff;
               negoff_in = neg_off[LEN_WIDTH-1:0];
               fill_in   = '0;
               look_in   = '0;
               rem_in    = '0;
               quo_in    = {mod_dividend, {(TOTAL_WIDTH - LEN_WIDTH){1'b0}}};
               step_in   = STEP_WIDTH'(MOD_STEPS);
               err_in    = ERR_NONE;
               if (req_op == OP_PUSH && nonneg_ff && req_value < 0) begin
                  err_in = ERR_NEGATIVE;
               end else if (req_op == OP_READ && !in_range) begin
                  err_in = ERR_RANGE;
               end
            end
         end
         ST_INDEX: begin
            if (step_ff == '0) begin
               idx_in = (op_ff == OP_PUSH) ? rem_ff[ADDR_WIDTH-1:0]
                                           : read_wrap[ADDR_WIDTH-1:0];
            end
         end
         ST_MODIFY: begin
            if (op_ff == OP_PUSH) begin
               tot_in    = push_tot[TOTAL_WIDTH-1:0];
               newest_in = idx_ff;
            end else begin
               look_in = old_smp;
            end
         end
         ST_FILL: begin
            fill_in = fill_ff + LEN_WIDTH'(1);
            if (fill_last) begin
               tot_in    = fill_prod[TOTAL_WIDTH-1:0];
               newest_in = len_m1[ADDR_WIDTH-1:0];
            end
         end
         ST_AVG_START: begin
            avg_neg_in = tot_ff[TOTAL_WIDTH-1];
            quo_in     = tot_ff[TOTAL_WIDTH-1] ? TOTAL_WIDTH'(-tot_ff) : TOTAL_WIDTH'(tot_ff);
            rem_in     = '0;
            step_in    = STEP_WIDTH'(DIV_STEPS);
         end
         ST_RESULT: begin
            if (out_load) begin
               sum_out_in  = tot_ff;
               look_out_in = look_ff;
               err_out_in  = err_ff;
               if (!avg_neg_ff) begin
                  avg_out_in = (quo_ff > AVG_POS_LIMIT) ? AVG_MAX : quo_ff[AVG_WIDTH-1:0];
               end else begin
                  avg_out_in = (quo_ff > AVG_NEG_LIMIT) ? AVG_MIN : -quo_ff[AVG_WIDTH-1:0];
               end
            end
         end
         default: ;
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= LEN_WIDTH'(WINDOW_LENGTH_RESET);
         nonneg_ff    <= 1'b0;
         newest_ff    <= ADDR_WIDTH'(NEWEST_RESET);
         tot_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         nonneg_ff    <= nonneg_in;
         newest_ff    <= newest_in;
         tot_ff       <= tot_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      len_ff      <= len_in;
      negoff_ff   <= negoff_in;
      idx_ff      <= idx_in;
      fill_ff     <= fill_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      avg_neg_ff  <= avg_neg_in;
      look_ff     <= look_in;
      err_ff      <= err_in;
      rvld_ff     <= vld_ff[idx_ff];
      sum_out_ff  <= sum_out_in;
      avg_out_ff  <= avg_out_in;
      look_out_ff <= look_out_in;
      err_out_ff  <= err_out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_running_sum     = sum_out_ff;
   assign rsp_average         = avg_out_ff;
   assign rsp_looked_up_value = look_out_ff;
   assign rsp_error_code      = err_out_ff;

endmodule

`default_nettype wire

// File: sv/mws_checker.sv
// Port-level checks of the moving window sum unit and their binding.
`default_nettype none

module mws_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_stall,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic signed [mws_pkg::TOTAL_WIDTH-1:0]   rsp_running_sum,
   input logic signed [mws_pkg::AVG_WIDTH-1:0]     rsp_average,
   input logic signed [mws_pkg::SAMPLE_WIDTH-1:0]  rsp_looked_up_value,
   input logic [1:0]                               rsp_error_code
);

   import mws_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_running_sum) &&
         $stable(rsp_average) && $stable(rsp_looked_up_value) && $stable(rsp_error_code))
      else $error("stalled result changed");

   // one item at a time: stall right after a transfer in
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while busy");

   // no looked-up sample alongside an error
   a_err_look: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |-> rsp_looked_up_value == '0)
      else $error("looked-up value set on error");

   // drop results at reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind moving_window_sum_unit mws_checker u_mws_checker (.*);

`default_nettype wire

// File: tb/moving_window_sum_unit_test.sv
// Self-checking testbench of the moving window sum unit: directed, wrap and random item streams.
`timescale 1ns / 1ps

module moving_window_sum_unit_test;
   import mws_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;

   typedef struct {
      logic signed [TOTAL_WIDTH-1:0]  sum;
      logic signed [AVG_WIDTH-1:0]    avg;
      logic signed [SAMPLE_WIDTH-1:0] looked;
      err_type                        err;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = OP_NONE;
   logic signed [SAMPLE_WIDTH-1:0] req_value = '0;
   logic signed [OFFSET_WIDTH-1:0] req_offset = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [TOTAL_WIDTH-1:0] rsp_running_sum;
   logic signed [AVG_WIDTH-1:0] rsp_average;
   logic signed [SAMPLE_WIDTH-1:0] rsp_looked_up_value;
   logic [1:0] rsp_error_code;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic signed [SAMPLE_WIDTH-1:0] window_ring [DEPTH];
   logic [ADDR_WIDTH-1:0] newest_slot;
   logic signed [TOTAL_WIDTH-1:0] window_sum;
   logic [LEN_WIDTH-1:0] cfg_length;
   logic cfg_nonneg;

   window_result_type pending_results[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit long_hold_req = 0;
   bit steady = 0;

   moving_window_sum_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_value           (req_value),
      .req_offset          (req_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_running_sum     (rsp_running_sum),
      .rsp_average         (rsp_average),
      .rsp_looked_up_value (rsp_looked_up_value),
      .rsp_error_code      (rsp_error_code),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic void clear_window();
      foreach (window_ring[i]) window_ring[i] = '0;
      newest_slot = ADDR_WIDTH'(NEWEST_RESET);
      window_sum = '0;
      cfg_length = LEN_WIDTH'(WINDOW_LENGTH_RESET);
      cfg_nonneg = 1'b0;
   endfunction

   function automatic int active_length();
      if (cfg_length == 0) return 1;
      if (cfg_length > DEPTH) return DEPTH;
      return int'(cfg_length);
   endfunction

   function automatic window_result_type advance_window(input op_type op,
                                                     input logic signed [SAMPLE_WIDTH-1:0] val,
                                                     input logic signed [OFFSET_WIDTH-1:0] off);
      int len;
      int slot;
      longint partial;
      longint quotient;
      window_result_type r;
      len = active_length();
      r.looked = '0;
      r.err = ERR_NONE;
      case (op)
         OP_PUSH: begin
            if (cfg_nonneg && val < 0) begin
               r.err = ERR_NEGATIVE;
            end else begin
               slot = (int'(newest_slot) + 1) % len;
               partial = longint'(window_sum) - longint'(window_ring[slot]);
               if (cfg_nonneg && partial < 0) partial = 0;
               window_sum = TOTAL_WIDTH'(partial + longint'(val));
               window_ring[slot] = val;
               newest_slot = ADDR_WIDTH'(slot);
            end
         end
         OP_READ: begin
            if (off <= 0 && int'(off) >= -(len - 1)) begin
               slot = ((int'(newest_slot) % len) + int'(off) + len) % len;
               r.looked = window_ring[slot];
            end else begin
               r.err = ERR_RANGE;
            end
         end
         OP_FILL: begin
            for (int i = 0; i < len; i++) window_ring[i] = val;
            window_sum = TOTAL_WIDTH'(longint'(len) * longint'(val));
            newest_slot = ADDR_WIDTH'(len - 1);
         end
         default: ;
      endcase
      quotient = longint'(window_sum) / longint'(len);
      if (quotient > 64'sd2147483647) quotient = 64'sd2147483647;
      if (quotient < -64'sd2147483648) quotient = -64'sd2147483648;
      r.sum = window_sum;
      r.avg = AVG_WIDTH'(quotient);
      return r;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_value(input logic nonneg);
      logic signed [SAMPLE_WIDTH-1:0] v;
      case ($urandom_range(9))
         0: v = 32'sh7fffffff;
         1: v = 32'sh80000000;
         2: v = '0;
         3: v = -1;
         4, 5: v = 32'($urandom_range(2097152)) - 32'd1048576;
         default: v = $urandom;
      endcase
      if (nonneg && $urandom_range(9) < 7) v[SAMPLE_WIDTH-1] = 1'b0;
      return v;
   endfunction

   function automatic logic signed [OFFSET_WIDTH-1:0] pick_offset(input int len);
      case ($urandom_range(7))
         0: return OFFSET_WIDTH'(1 - len);
         1: return OFFSET_WIDTH'(-len);
         2: return OFFSET_WIDTH'($urandom);
         default: return OFFSET_WIDTH'(-$urandom_range(len - 1));
      endcase
   endfunction

   task automatic send_item(input op_type op, input logic signed [SAMPLE_WIDTH-1:0] val,
                            input logic signed [OFFSET_WIDTH-1:0] off);
      window_result_type expected;
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= val;
      req_offset <= off;
      do @(posedge clock); while (req_stall);
      expected = advance_window(op, val, off);
      pending_results = {pending_results, expected};
   endtask

   task automatic send_random_item();
      int len;
      int pick;
      len = active_length();
      pick = $urandom_range(99);
      if (pick < 55) send_item(OP_PUSH, pick_value(cfg_nonneg), pick_offset(len));
      else if (pick < 88) send_item(OP_READ, pick_value(1'b0), pick_offset(len));
      else if (pick < 95) send_item(OP_FILL, pick_value(1'b0), pick_offset(len));
      else send_item(OP_NONE, pick_value(1'b0), pick_offset(len));
   endtask

   task automatic write_registers(input logic [LEN_WIDTH-1:0] length, input logic nonneg);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= CSR_DATA_WIDTH'(length);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_NONNEGATIVE;
      csr_wdata <= CSR_DATA_WIDTH'(nonneg);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_length = length;
      cfg_nonneg = nonneg;
   endtask

   task automatic test_directed_cases();
      send_item(OP_READ, 0, 0);
      send_item(OP_READ, 0, -15);
      send_item(OP_READ, 0, -16);
      send_item(OP_READ, 0, 9'sd255);
      send_item(OP_PUSH, 32'sh7fffffff, 0);
      send_item(OP_PUSH, 32'sh80000000, 0);
      send_item(OP_PUSH, -1, 0);
      send_item(OP_READ, 0, -1);
      send_item(OP_NONE, 32'sh12345678, -3);
      send_item(OP_FILL, 32'sh7fffffff, 0);
      write_registers(256, 1'b0);
      send_item(OP_FILL, 32'sh7fffffff, 0);
      send_item(OP_READ, 0, -255);
      write_registers(1, 1'b0);
      send_item(OP_READ, 0, 0);
      write_registers(256, 1'b0);
      send_item(OP_FILL, 32'sh80000000, 0);
      write_registers(2, 1'b0);
      send_item(OP_PUSH, 0, 0);
      write_registers(4, 1'b1);
      send_item(OP_PUSH, 32'sh80000000, 0);
      send_item(OP_FILL, -5 << 16, 0);
      send_item(OP_PUSH, 1, 0);
      send_item(OP_PUSH, 0, 0);
      write_registers(0, 1'b1);
      send_item(OP_PUSH, 32'sh00010000, 0);
      send_item(OP_READ, 0, -1);
      write_registers(511, 1'b0);
      send_item(OP_READ, 0, 9'h100);
      send_item(OP_READ, 0, -255);
   endtask

   task automatic test_total_wrap();
      write_registers(256, 1'b0);
      send_item(OP_FILL, 32'sh80000000, 0);
      write_registers(1, 1'b0);
      send_item(OP_FILL, 32'sh7fffffff, 0);
      write_registers(256, 1'b0);
      repeat (140) send_item(OP_PUSH, 32'sh7fffffff - $urandom_range(65535), pick_offset(256));
   endtask

   task automatic test_random_settings();
      int unsigned length_set[10] = '{16, 1, 2, 3, 256, 255, 0, 300, 511, 0};
      logic [LEN_WIDTH-1:0] length;
      for (int phase = 0; phase < 10; phase++) begin
         length = (phase == 9) ? LEN_WIDTH'($urandom_range(1, 256))
                               : LEN_WIDTH'(length_set[phase]);
         write_registers(length, phase[0]);
         repeat (45) send_random_item();
      end
   endtask

   task automatic test_back_to_back();
      write_registers(LEN_WIDTH'($urandom_range(1, 64)), 1'b0);
      steady = 1;
      repeat (60) send_random_item();
      steady = 0;
   endtask

   task automatic test_receiver_hold();
      write_registers(8, 1'b0);
      long_hold_req = 1;
      repeat (20) send_random_item();
   endtask

   task automatic test_drain_pause();
      write_registers(5, 1'b1);
      repeat (12) send_random_item();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) send_random_item();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req <= 0;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && $urandom_range(99) < 19;
      end
   end

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_running_sum !== want.sum) begin
               $error("running_sum: expected %0d, got %0d", want.sum, rsp_running_sum);
               mismatch_count++;
            end
            if (rsp_average !== want.avg) begin
               $error("average: expected %0d, got %0d", want.avg, rsp_average);
               mismatch_count++;
            end
            if (rsp_looked_up_value !== want.looked) begin
               $error("looked_up_value: expected %0d, got %0d", want.looked,
                      rsp_looked_up_value);
               mismatch_count++;
            end
            if (rsp_error_code !== want.err) begin
               $error("error_code: expected %0d, got %0d", want.err, rsp_error_code);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      clear_window();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_total_wrap();
      test_random_settings();
      test_back_to_back();
      test_receiver_hold();
      test_drain_pause();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
